### hdl/swrl_pkg.sv
// ============================================================================
// swrl_pkg - sliding window rate limiter shared definitions
// Sizes, widths, reset values and codes used by the limiter and its checker.
// ============================================================================
`default_nettype none

package swrl_pkg;

    localparam int SESSIONS   = 16;
    localparam int RING_DEPTH = 16;

    localparam int SESS_W  = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int SLOT_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int COUNT_W = 5;
    localparam int ADDR_W  = ((SESSIONS * RING_DEPTH) > 1) ? $clog2(SESSIONS * RING_DEPTH) : 1;
    localparam int DATA_W  = 32;

    localparam int CFG_IDX_W = 2;

    localparam logic [31:0] RST_MAX_BODY_BYTES      = 32'd1048576;
    localparam logic [4:0]  RST_MAX_ACTIVE_SESSIONS = 5'd16;
    localparam logic [4:0]  RST_MAX_PER_WINDOW      = 5'd10;
    localparam logic [15:0] RST_WINDOW_MS           = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_BODY_BYTES      = 2'd0,
        CFG_MAX_ACTIVE_SESSIONS = 2'd1,
        CFG_MAX_PER_WINDOW      = 2'd2,
        CFG_WINDOW_MS           = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        REQ_CHECK    = 2'd0,
        REQ_START    = 2'd1,
        REQ_COMPLETE = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        DEC_ALLOW        = 2'd0,
        DEC_RATE_LIMITED = 2'd1,
        DEC_TOO_LARGE    = 2'd2
    } decision_t;

endpackage : swrl_pkg

`default_nettype wire

### hdl/sliding_window_rate_limiter_unit.sv
// ============================================================================
// sliding_window_rate_limiter_unit - per-session sliding window admission
// Keeps a ring of start stamps per session plus active marks, and answers
// check beats with allow, rate limited or too large.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) takes one beat: req_type, session,
//   body_size, now_ms. Output channel (out_valid/out_ready) returns exactly
//   one result beat per input beat: decision, window_count, active_count,
//   ring_overflow. Configuration is a plain write port (cfg_wr_en, cfg_index,
//   cfg_data); the user must write it only while the block is idle, which
//   the block does not enforce. Start, complete, unused type and early
//   check answers pass from accept through decide to the finish step. A
//   check that reaches the window test adds a read step and a compare step
//   that repeats while the head stamp is expired, ending at a live stamp or
//   once every held stamp is popped. The pop loop retires one stamp per
//   cycle through the single age subtract/compare, fed by the registered
//   read port of the stamp memory; that loop sets the rate. in_ready is high
//   only while the sequencer is idle and rises together with out_valid. The
//   result sits in an output register, so a new beat is taken while a
//   result still waits; the sequencer holds its last step while that
//   register is full and out_ready is low. Reset clears ring heads, counts,
//   active marks and the configuration to its defaults. The stamp memory
//   is not cleared: only written slots are ever read.
`default_nettype none

module sliding_window_rate_limiter_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration write port
    input  wire logic                          cfg_wr_en,
    input  wire logic [swrl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    req_type,
    input  wire logic [3:0]                    session,
    input  wire logic [31:0]                   body_size,
    input  wire logic [31:0]                   now_ms,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         decision,
    output logic [4:0]                         window_count,
    output logic [4:0]                         active_count,
    output logic                               ring_overflow
);

    import swrl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PRUNE_RD,
        ST_PRUNE_CMP,
        ST_FINISH
    } state_t;

    typedef logic [SESS_W-1:0]  sess_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [ADDR_W-1:0]  addr_t;

    // Advance a ring slot by one, wrapping at the ring depth.
    function automatic slot_t slot_inc(input slot_t slot);
        if ({1'b0, slot} == (SLOT_W + 1)'(RING_DEPTH - 1))
            return '0;
        return slot_t'({1'b0, slot} + (SLOT_W + 1)'(1));
    endfunction

    // Slot of the tail: head plus count, one wrap at most.
    function automatic slot_t slot_add(input slot_t head, input count_t cnt);
        logic [COUNT_W:0] sum;
        sum = (COUNT_W + 1)'(head) + (COUNT_W + 1)'(cnt);
        if (sum >= (COUNT_W + 1)'(RING_DEPTH))
            sum = sum - (COUNT_W + 1)'(RING_DEPTH);
        return slot_t'(sum);
    endfunction

    function automatic addr_t mem_addr(input sess_t s, input slot_t slot);
        return addr_t'(s) * addr_t'(RING_DEPTH) + addr_t'(slot);
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [31:0] max_body_bytes_reg;
    logic [4:0]  max_active_sessions_reg;
    logic [4:0]  max_per_window_reg;
    logic [15:0] window_ms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_body_bytes_reg      <= RST_MAX_BODY_BYTES;
            max_active_sessions_reg <= RST_MAX_ACTIVE_SESSIONS;
            max_per_window_reg      <= RST_MAX_PER_WINDOW;
            window_ms_reg           <= RST_WINDOW_MS;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MAX_BODY_BYTES:      max_body_bytes_reg      <= cfg_data;
                CFG_MAX_ACTIVE_SESSIONS: max_active_sessions_reg <= cfg_data[4:0];
                CFG_MAX_PER_WINDOW:      max_per_window_reg      <= cfg_data[4:0];
                CFG_WINDOW_MS:           window_ms_reg           <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // beat capture and session state
    // ------------------------------------------------------------------
    state_t        state_reg;
    logic [1:0]    req_type_reg;
    sess_t         sess_reg;
    logic [31:0]   body_size_reg;
    logic [31:0]   now_ms_reg;
    decision_t     dec_reg;
    logic          ovf_reg;

    slot_t         ring_head_reg  [SESSIONS];
    count_t        ring_count_reg [SESSIONS];
    logic [SESSIONS-1:0] active_flags_reg;
    count_t        active_total_reg;

    logic          out_valid_reg;
    decision_t     decision_reg;
    count_t        window_count_reg;
    count_t        active_count_reg;
    logic          ring_overflow_reg;

    // stamp memory with registered read
    logic [DATA_W-1:0] stamp_mem [SESSIONS * RING_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              mem_wr_en;
    addr_t             mem_wr_addr;
    logic              mem_rd_en;
    addr_t             mem_rd_addr;

    // current session view
    slot_t   cur_head;
    count_t  cur_count;
    slot_t   head_next;
    logic    ring_full;
    logic [31:0] age;
    logic    expired;
    logic    out_free;

    assign cur_head  = ring_head_reg[sess_reg];
    assign cur_count = ring_count_reg[sess_reg];
    assign head_next = slot_inc(cur_head);
    assign ring_full = (cur_count >= count_t'(RING_DEPTH));

    // shared age unit: one subtract modulo 2^32 and one compare
    assign age      = now_ms_reg - rd_data_reg;
    assign expired  = (age >= {16'd0, window_ms_reg});
    assign out_free = !out_valid_reg || out_ready;

    assign in_ready = (state_reg == ST_IDLE);

    // memory port control
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = mem_addr(sess_reg, ring_full ? cur_head : slot_add(cur_head, cur_count));
        mem_rd_en   = 1'b0;
        mem_rd_addr = mem_addr(sess_reg, cur_head);
        unique case (state_reg)
            ST_DECIDE:
            begin
                mem_wr_en = (req_type_reg == REQ_START);
            end
            ST_PRUNE_RD:
            begin
                mem_rd_en = 1'b1;
            end
            ST_PRUNE_CMP:
            begin
                // fetch the next head while popping this one
                mem_rd_en   = expired;
                mem_rd_addr = mem_addr(sess_reg, head_next);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            stamp_mem[mem_wr_addr] <= now_ms_reg;
        if (mem_rd_en)
            rd_data_reg <= stamp_mem[mem_rd_addr];
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            active_flags_reg  <= '0;
            active_total_reg  <= '0;
            out_valid_reg     <= 1'b0;
            dec_reg           <= DEC_ALLOW;
            ovf_reg           <= 1'b0;
            for (int i = 0; i < SESSIONS; i++)
            begin
                ring_head_reg[i]  <= '0;
                ring_count_reg[i] <= '0;
            end
        end
        else
        begin
            // drop the result once the receiver takes it; the finish step
            // reloads the register itself
            if (out_valid_reg && out_ready && state_reg != ST_FINISH)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_type_reg  <= req_type;
                        sess_reg      <= sess_t'(session);
                        body_size_reg <= body_size;
                        now_ms_reg    <= now_ms;
                        dec_reg       <= DEC_ALLOW;
                        ovf_reg       <= 1'b0;
                        state_reg     <= ST_DECIDE;
                    end
                end

                ST_DECIDE:
                begin
                    unique case (req_type_reg)
                        REQ_CHECK:
                        begin
                            priority if (body_size_reg > max_body_bytes_reg)
                            begin
                                dec_reg   <= DEC_TOO_LARGE;
                                state_reg <= ST_FINISH;
                            end
                            else if (active_total_reg >= max_active_sessions_reg)
                            begin
                                dec_reg   <= DEC_RATE_LIMITED;
                                state_reg <= ST_FINISH;
                            end
                            else if (cur_count != '0)
                                state_reg <= ST_PRUNE_RD;
                            else
                            begin
                                state_reg <= ST_FINISH;
                                if (cur_count >= max_per_window_reg)
                                    dec_reg <= DEC_RATE_LIMITED;
                            end
                        end
                        REQ_START:
                        begin
                            state_reg <= ST_FINISH;
                            if (!active_flags_reg[sess_reg])
                            begin
                                active_flags_reg[sess_reg] <= 1'b1;
                                active_total_reg           <= active_total_reg + count_t'(1);
                            end
                            if (ring_full)
                            begin
                                ring_head_reg[sess_reg] <= head_next;
                                ovf_reg                 <= 1'b1;
                            end
                            else
                                ring_count_reg[sess_reg] <= cur_count + count_t'(1);
                        end
                        REQ_COMPLETE:
                        begin
                            state_reg <= ST_FINISH;
                            if (active_flags_reg[sess_reg])
                            begin
                                active_flags_reg[sess_reg] <= 1'b0;
                                active_total_reg           <= active_total_reg - count_t'(1);
                            end
                        end
                        default:
                        begin
                            state_reg <= ST_FINISH;
                        end
                    endcase
                end

                ST_PRUNE_RD:
                begin
                    state_reg <= ST_PRUNE_CMP;
                end

                ST_PRUNE_CMP:
                begin
                    if (expired)
                    begin
                        ring_head_reg[sess_reg]  <= head_next;
                        ring_count_reg[sess_reg] <= cur_count - count_t'(1);
                        if (cur_count == count_t'(1))
                        begin
                            state_reg <= ST_FINISH;
                            if (max_per_window_reg == '0)
                                dec_reg <= DEC_RATE_LIMITED;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_FINISH;
                        if (cur_count >= max_per_window_reg)
                            dec_reg <= DEC_RATE_LIMITED;
                    end
                end

                ST_FINISH:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        decision_reg      <= dec_reg;
                        window_count_reg  <= cur_count;
                        active_count_reg  <= active_total_reg;
                        ring_overflow_reg <= ovf_reg;
                        state_reg         <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign decision      = decision_reg;
    assign window_count  = window_count_reg;
    assign active_count  = active_count_reg;
    assign ring_overflow = ring_overflow_reg;

endmodule : sliding_window_rate_limiter_unit

`default_nettype wire

### hdl/swrl_checker.sv
// ============================================================================
// swrl_checker - port level checks for the sliding window rate limiter
// Watches the top level ports and flags sequencing and result slips.
// ============================================================================
`default_nettype none

module swrl_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] decision,
    input wire logic [4:0] window_count,
    input wire logic [4:0] active_count,
    input wire logic       ring_overflow
);

    import swrl_pkg::*;

    // one beat in work at a time: ready drops right after an accept
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready stayed high after an accepted beat");

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(decision)
            && $stable(window_count) && $stable(active_count) && $stable(ring_overflow))
        else $error("result beat changed while stalled");

    // an overwrite happens only on a full ring of a start beat
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ring_overflow |->
            window_count == 5'(RING_DEPTH) && decision == DEC_ALLOW && active_count != 5'd0)
        else $error("ring_overflow without a full ring");

    // counts never exceed their capacities
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> window_count <= 5'(RING_DEPTH) && active_count <= 5'(SESSIONS))
        else $error("count out of range");

endmodule : swrl_checker

bind sliding_window_rate_limiter_unit swrl_checker u_swrl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .decision      (decision),
    .window_count  (window_count),
    .active_count  (active_count),
    .ring_overflow (ring_overflow)
);

`default_nettype wire
